>>> rtl/core/assert_macros.svh
// assertion macros for the arp cache rtl, used by the back part
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// expression that must always hold outside reset
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error(msg);

`endif

>>> rtl/core/arpc_pkg.sv
// package: constants, codes and helper functions for the arp cache
package arpc_pkg;

   localparam int MAP_DEPTH = 32;
   localparam int REQ_DEPTH = 8;
   localparam int MAP_IDX_W = $clog2(MAP_DEPTH);
   localparam int REQ_IDX_W = (REQ_DEPTH > 1) ? $clog2(REQ_DEPTH) : 1;
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_IDX_W = 1;
   localparam int QUEUE_CNT_W = 2;

   localparam logic [7:0]  MAX_AGE_RESET   = 8'd15;
   localparam logic [3:0]  RETRY_INT_RESET = 4'd1;
   localparam logic [3:0]  MAX_RETRY_RESET = 4'd5;
   localparam logic [15:0] LFSR_SEED       = 16'hACE1;

   // operation codes
   typedef enum logic [1:0] {
      OP_LOOKUP = 2'd0,
      OP_INSERT = 2'd1,
      OP_APPEND = 2'd2,
      OP_TICK   = 2'd3
   } op_type;

   // result kinds
   typedef enum logic [2:0] {
      KIND_MISS        = 3'd0,
      KIND_HIT         = 3'd1,
      KIND_QUEUED      = 3'd2,
      KIND_SEND        = 3'd3,
      KIND_RELEASE     = 3'd4,
      KIND_UNREACHABLE = 3'd5,
      KIND_FULL        = 3'd6,
      KIND_DONE        = 3'd7
   } kind_type;

   // configuration register indexes
   typedef enum logic [1:0] {
      CSR_MAX_AGE     = 2'd0,
      CSR_RETRY_INT   = 2'd1,
      CSR_MAX_RETRIES = 2'd2
   } csr_idx_type;

   // classified command passed from front to back
   typedef struct packed {
      op_type                 op;
      logic [31:0]            ip;
      logic [47:0]            mac;
      logic [3:0]             iface;
      logic                   map_hit;
      logic [MAP_IDX_W-1:0]   map_idx;
      logic                   map_free;
      logic                   req_match;
      logic                   req_free;
      logic [REQ_IDX_W-1:0]   req_idx;
   } cmd_type;

   // one result item
   typedef struct packed {
      kind_type    kind;
      logic [31:0] ip;
      logic [47:0] mac;
      logic [3:0]  iface;
      logic        last;
   } rsp_type;

   // lfsr step: x^16+x^14+x^13+x^11+1, shift right
   function automatic logic [15:0] lfsr_next(input logic [15:0] l);
      logic b;
      b = l[0] ^ l[2] ^ l[3] ^ l[5];
      return {b, l[15:1]};
   endfunction

endpackage

>>> rtl/core/arpc_ram.sv
// generic simple dual-port ram (one write port, one read port) with registered read
module arpc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/arpc_queue.sv
// short command queue between front and back
module arpc_queue
   import arpc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   output logic    full,
   input  logic    pop,
   output logic    empty,
   output cmd_type head
);

   cmd_type                 slot_ff [QUEUE_DEPTH];
   logic [QUEUE_IDX_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_IDX_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]  count_ff, count_in;
   logic                    do_push, do_pop;

   assign full    = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = slot_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // payload storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> rtl/core/arpc_front.sv
// front: accepts transfers and classifies them against the tag tables
module arpc_front
   import arpc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_operation,
   input  logic [31:0]          req_ip_addr,
   input  logic [47:0]          req_mac_addr,
   input  logic [3:0]           req_iface_id,
   input  logic [MAP_DEPTH-1:0] map_valid,
   input  logic [31:0]          map_ip [MAP_DEPTH],
   input  logic [REQ_DEPTH-1:0] pend_valid,
   input  logic [31:0]          pend_ip [REQ_DEPTH],
   input  logic [3:0]           pend_iface [REQ_DEPTH],
   input  logic                 back_busy,
   input  logic                 q_full,
   input  logic                 q_empty,
   output logic                 q_push,
   output cmd_type              q_data
);

   logic                 busy_ff, busy_in;
   logic [MAP_DEPTH-1:0] map_match;
   logic [REQ_DEPTH-1:0] pend_match;
   logic                 map_hit, map_free, req_match, req_free;
   logic [MAP_IDX_W-1:0] hit_idx, free_idx;
   logic [REQ_IDX_W-1:0] rm_idx, rf_idx;

   // tables change under the back part, so one item is classified at a time
   assign req_ready = !busy_ff && !q_full && q_empty && !back_busy;
   assign q_push    = req_valid && req_ready;

   // parallel compares and priority pick
   always_comb begin
      map_hit   = 1'b0;
      map_free  = 1'b0;
      hit_idx   = '0;
      free_idx  = '0;
      req_match = 1'b0;
      req_free  = 1'b0;
      rm_idx    = '0;
      rf_idx    = '0;
      for (int i = 0; i < MAP_DEPTH; i++) begin
         map_match[i] = map_valid[i] && (map_ip[i] == req_ip_addr);
      end
      for (int i = MAP_DEPTH - 1; i >= 0; i--) begin
         if (map_match[i]) begin
            map_hit = 1'b1;
            hit_idx = MAP_IDX_W'(i);
         end
         if (!map_valid[i]) begin
            map_free = 1'b1;
            free_idx = MAP_IDX_W'(i);
         end
      end
      for (int i = 0; i < REQ_DEPTH; i++) begin
         pend_match[i] = pend_valid[i] && (pend_ip[i] == req_ip_addr)
                         && (pend_iface[i] == req_iface_id);
      end
      for (int i = REQ_DEPTH - 1; i >= 0; i--) begin
         if (pend_match[i]) begin
            req_match = 1'b1;
            rm_idx    = REQ_IDX_W'(i);
         end
         if (!pend_valid[i]) begin
            req_free = 1'b1;
            rf_idx   = REQ_IDX_W'(i);
         end
      end
   end

   // command build
   always_comb begin
      q_data.op        = op_type'(req_operation);
      q_data.ip        = req_ip_addr;
      q_data.mac       = req_mac_addr;
      q_data.iface     = req_iface_id;
      q_data.map_hit   = map_hit;
      q_data.map_idx   = (req_operation == OP_LOOKUP) ? hit_idx : free_idx;
      q_data.map_free  = map_free;
      q_data.req_match = req_match;
      q_data.req_free  = req_free;
      q_data.req_idx   = req_match ? rm_idx : rf_idx;
   end

   // hold off the next transfer in the cycle after a push while the queue settles
   assign busy_in = q_push;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

endmodule

>>> rtl/core/arpc_back.sv
// back: executes commands, walks tables and emits results
module arpc_back
   import arpc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_empty,
   input  cmd_type              q_head,
   output logic                 q_pop,
   output logic                 busy,
   input  logic [7:0]           max_age,
   input  logic [3:0]           retry_interval,
   input  logic [3:0]           max_retries,
   output logic [MAP_DEPTH-1:0] map_valid,
   output logic [31:0]          map_ip [MAP_DEPTH],
   output logic [REQ_DEPTH-1:0] pend_valid,
   output logic [31:0]          pend_ip [REQ_DEPTH],
   output logic [3:0]           pend_iface [REQ_DEPTH],
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data
);

   `include "assert_macros.svh"

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_RELEASE,
      ST_AGE,
      ST_RETRY,
      ST_DONE
   } state_type;

   localparam logic [REQ_IDX_W:0] REQ_LAST = (REQ_IDX_W+1)'(REQ_DEPTH - 1);
   localparam logic [MAP_IDX_W:0] MAP_LAST = (MAP_IDX_W+1)'(MAP_DEPTH - 1);

   state_type            state_ff;
   cmd_type              cmd_ff;
   logic [MAP_DEPTH-1:0] map_valid_ff;
   logic [31:0]          map_ip_ff [MAP_DEPTH];
   logic [7:0]           map_age_ff [MAP_DEPTH];
   logic [REQ_DEPTH-1:0] pend_valid_ff;
   logic [31:0]          pend_ip_ff [REQ_DEPTH];
   logic [3:0]           pend_iface_ff [REQ_DEPTH];
   logic [3:0]           pend_elapsed_ff [REQ_DEPTH];
   logic [3:0]           pend_retries_ff [REQ_DEPTH];
   logic [15:0]          lfsr_ff;
   logic [MAP_IDX_W:0]   map_cnt_ff;
   logic [REQ_IDX_W:0]   req_cnt_ff;
   logic                 out_valid_ff;
   rsp_type              out_ff;

   logic                 mac_wr;
   logic [MAP_IDX_W-1:0] mac_wr_idx;
   logic [47:0]          mac_rd;
   logic                 out_free;
   logic [REQ_IDX_W-1:0] ri;
   logic [MAP_IDX_W-1:0] mi;
   logic [7:0]           age_inc;
   logic [3:0]           el_inc;
   logic [MAP_IDX_W-1:0] ins_idx;

   assign map_valid  = map_valid_ff;
   assign map_ip     = map_ip_ff;
   assign pend_valid = pend_valid_ff;
   assign pend_ip    = pend_ip_ff;
   assign pend_iface = pend_iface_ff;
   assign busy       = (state_ff != ST_IDLE) || out_valid_ff;
   assign rsp_valid  = out_valid_ff;
   assign rsp_data   = out_ff;
   assign out_free   = !out_valid_ff || rsp_ready;
   assign q_pop      = (state_ff == ST_IDLE) && !q_empty && !out_valid_ff;
   assign ri         = req_cnt_ff[REQ_IDX_W-1:0];
   assign mi         = map_cnt_ff[MAP_IDX_W-1:0];
   assign age_inc    = (map_age_ff[mi] == 8'hFF) ? 8'hFF : map_age_ff[mi] + 8'd1;
   assign el_inc     = (pend_elapsed_ff[ri] == 4'hF) ? 4'hF
                       : pend_elapsed_ff[ri] + 4'd1;
   assign ins_idx    = q_head.map_free ? q_head.map_idx : lfsr_ff[MAP_IDX_W-1:0];
   assign mac_wr     = q_pop && (q_head.op == OP_INSERT);
   assign mac_wr_idx = ins_idx;

   // mac store
   arpc_ram #(.WIDTH(48), .DEPTH(MAP_DEPTH)) u_mac_ram (
      .clock   (clock),
      .wr_en   (mac_wr),
      .wr_addr (mac_wr_idx),
      .wr_data (q_head.mac),
      .rd_addr (q_head.map_idx),
      .rd_data (mac_rd)
   );

   // sequencer with tables and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         map_valid_ff  <= '0;
         pend_valid_ff <= '0;
         lfsr_ff       <= LFSR_SEED;
         out_valid_ff  <= 1'b0;
         map_cnt_ff    <= '0;
         req_cnt_ff    <= '0;
      end else begin
         if (out_valid_ff && rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (q_pop) begin
                  cmd_ff     <= q_head;
                  map_cnt_ff <= '0;
                  req_cnt_ff <= '0;
                  unique case (q_head.op)
                     OP_LOOKUP: begin
                        state_ff <= ST_LOOKUP;
                     end
                     OP_INSERT: begin
                        map_ip_ff[ins_idx]  <= q_head.ip;
                        map_age_ff[ins_idx] <= '0;
                        map_valid_ff[ins_idx] <= 1'b1;
                        if (!q_head.map_free) begin
                           lfsr_ff <= lfsr_next(lfsr_ff);
                        end
                        state_ff <= ST_RELEASE;
                     end
                     OP_APPEND: begin
                        out_valid_ff <= 1'b1;
                        out_ff.ip    <= q_head.ip;
                        out_ff.mac   <= '0;
                        out_ff.iface <= q_head.iface;
                        out_ff.last  <= 1'b1;
                        if (q_head.req_match) begin
                           out_ff.kind <= KIND_QUEUED;
                        end else if (q_head.req_free) begin
                           out_ff.kind <= KIND_SEND;
                           pend_valid_ff[q_head.req_idx]   <= 1'b1;
                           pend_ip_ff[q_head.req_idx]      <= q_head.ip;
                           pend_iface_ff[q_head.req_idx]   <= q_head.iface;
                           pend_elapsed_ff[q_head.req_idx] <= '0;
                           pend_retries_ff[q_head.req_idx] <= '0;
                        end else begin
                           out_ff.kind <= KIND_FULL;
                        end
                     end
                     default: begin
                        state_ff <= ST_AGE;
                     end
                  endcase
               end
            end
            ST_LOOKUP: begin
               // mac read data is ready now
               out_valid_ff <= 1'b1;
               out_ff.kind  <= cmd_ff.map_hit ? KIND_HIT : KIND_MISS;
               out_ff.ip    <= cmd_ff.ip;
               out_ff.mac   <= cmd_ff.map_hit ? mac_rd : '0;
               out_ff.iface <= '0;
               out_ff.last  <= 1'b1;
               state_ff     <= ST_IDLE;
            end
            ST_RELEASE: begin
               if (out_free) begin
                  if (pend_valid_ff[ri] && pend_ip_ff[ri] == cmd_ff.ip) begin
                     out_valid_ff <= 1'b1;
                     out_ff.kind  <= KIND_RELEASE;
                     out_ff.ip    <= cmd_ff.ip;
                     out_ff.mac   <= cmd_ff.mac;
                     out_ff.iface <= pend_iface_ff[ri];
                     out_ff.last  <= 1'b0;
                     pend_valid_ff[ri] <= 1'b0;
                  end
                  if (req_cnt_ff == REQ_LAST) begin
                     state_ff <= ST_DONE;
                  end else begin
                     req_cnt_ff <= req_cnt_ff + 1'b1;
                  end
               end
            end
            ST_AGE: begin
               if (map_valid_ff[mi]) begin
                  map_age_ff[mi] <= age_inc;
                  if (age_inc >= max_age) begin
                     map_valid_ff[mi] <= 1'b0;
                  end
               end
               if (map_cnt_ff == MAP_LAST) begin
                  state_ff <= ST_RETRY;
               end else begin
                  map_cnt_ff <= map_cnt_ff + 1'b1;
               end
            end
            ST_RETRY: begin
               if (out_free) begin
                  if (pend_valid_ff[ri]) begin
                     pend_elapsed_ff[ri] <= el_inc;
                     if (el_inc > retry_interval
                         && pend_retries_ff[ri] < max_retries) begin
                        out_valid_ff <= 1'b1;
                        out_ff.kind  <= KIND_SEND;
                        out_ff.ip    <= pend_ip_ff[ri];
                        out_ff.mac   <= '0;
                        out_ff.iface <= pend_iface_ff[ri];
                        out_ff.last  <= 1'b0;
                        pend_elapsed_ff[ri] <= '0;
                        if (pend_retries_ff[ri] != 4'hF) begin
                           pend_retries_ff[ri] <= pend_retries_ff[ri] + 4'd1;
                        end
                     end else if (pend_retries_ff[ri] >= max_retries) begin
                        out_valid_ff <= 1'b1;
                        out_ff.kind  <= KIND_UNREACHABLE;
                        out_ff.ip    <= pend_ip_ff[ri];
                        out_ff.mac   <= '0;
                        out_ff.iface <= pend_iface_ff[ri];
                        out_ff.last  <= 1'b0;
                        pend_valid_ff[ri] <= 1'b0;
                     end
                  end
                  if (req_cnt_ff == REQ_LAST) begin
                     state_ff <= ST_DONE;
                  end else begin
                     req_cnt_ff <= req_cnt_ff + 1'b1;
                  end
               end
            end
            ST_DONE: begin
               if (out_free) begin
                  out_valid_ff <= 1'b1;
                  out_ff.kind  <= KIND_DONE;
                  out_ff.ip    <= '0;
                  out_ff.mac   <= '0;
                  out_ff.iface <= '0;
                  out_ff.last  <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // a command is only taken when the output register is empty
   `ASSERT_IMPL(a_pop_idle, clock, reset, q_pop, !out_valid_ff && state_ff == ST_IDLE,
      "command popped while back part busy")
   // a stalled result holds
   `ASSERT_IMPL(a_rsp_hold, clock, reset, out_valid_ff && !rsp_ready,
      ##1 out_valid_ff && $stable(out_ff), "result changed while stalled")
   // walks only run while busy
   `ASSERT_ALWAYS(a_busy, clock, reset, (state_ff == ST_IDLE) || busy,
      "busy low during a walk")

endmodule

>>> rtl/core/arp_cache_with_pending_requests_unit.sv
// top level: arp cache with pending request table
//
//  channel | direction | handshake        | payload
//  req     | in        | req_valid/ready  | operation, ip, mac, iface
//  rsp     | out       | rsp_valid/ready  | kind, ip, mac, iface, last
//  csr     | in        | csr_write_enable | index, data (no read-back)
//
// lookup: popped, then the result follows from the registered mac read.
// append: one result, registered as the command is popped.
// insert: independent of MAP_DEPTH, one step per pending slot.
// tick: walks map then pending slots, one entry per cycle unless a result stalls.
// reset is synchronous; all tables empty, no clearing pass.
// a stalled result holds the walk; the front takes a new item once the back idles.
module arp_cache_with_pending_requests_unit
   import arpc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_operation,
   input  logic [31:0] req_ip_addr,
   input  logic [47:0] req_mac_addr,
   input  logic [3:0]  req_iface_id,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_kind,
   output logic [31:0] rsp_result_ip,
   output logic [47:0] rsp_result_mac,
   output logic [3:0]  rsp_result_iface,
   output logic        rsp_last,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_write_data
);

   logic [7:0]           max_age_ff;
   logic [3:0]           retry_int_ff;
   logic [3:0]           max_retries_ff;
   logic                 q_push, q_pop, q_full, q_empty, back_busy;
   cmd_type              q_data, q_head;
   rsp_type              rsp_data;
   logic [MAP_DEPTH-1:0] map_valid;
   logic [31:0]          map_ip [MAP_DEPTH];
   logic [REQ_DEPTH-1:0] pend_valid;
   logic [31:0]          pend_ip [REQ_DEPTH];
   logic [3:0]           pend_iface [REQ_DEPTH];

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         max_age_ff     <= MAX_AGE_RESET;
         retry_int_ff   <= RETRY_INT_RESET;
         max_retries_ff <= MAX_RETRY_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_idx_type'(csr_index))
            CSR_MAX_AGE:     max_age_ff     <= csr_write_data;
            CSR_RETRY_INT:   retry_int_ff   <= csr_write_data[3:0];
            CSR_MAX_RETRIES: max_retries_ff <= csr_write_data[3:0];
            default: ;
         endcase
      end
   end

   arpc_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .req_ip_addr   (req_ip_addr),
      .req_mac_addr  (req_mac_addr),
      .req_iface_id  (req_iface_id),
      .map_valid     (map_valid),
      .map_ip        (map_ip),
      .pend_valid    (pend_valid),
      .pend_ip       (pend_ip),
      .pend_iface    (pend_iface),
      .back_busy     (back_busy),
      .q_full        (q_full),
      .q_empty       (q_empty),
      .q_push        (q_push),
      .q_data        (q_data)
   );

   arpc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_data),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .head      (q_head)
   );

   arpc_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_empty        (q_empty),
      .q_head         (q_head),
      .q_pop          (q_pop),
      .busy           (back_busy),
      .max_age        (max_age_ff),
      .retry_interval (retry_int_ff),
      .max_retries    (max_retries_ff),
      .map_valid      (map_valid),
      .map_ip         (map_ip),
      .pend_valid     (pend_valid),
      .pend_ip        (pend_ip),
      .pend_iface     (pend_iface),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data)
   );

   // result fields
   assign rsp_kind         = rsp_data.kind;
   assign rsp_result_ip    = rsp_data.ip;
   assign rsp_result_mac   = rsp_data.mac;
   assign rsp_result_iface = rsp_data.iface;
   assign rsp_last         = rsp_data.last;

endmodule
